[rtl/grain_boundary_energy_mobility_macros.svh]
// ----------------------------------------------------------------------------
// Grain boundary energy/mobility assertion macros
// Shared property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef GRAIN_BOUNDARY_ENERGY_MOBILITY_MACROS_SVH
`define GRAIN_BOUNDARY_ENERGY_MOBILITY_MACROS_SVH

// Property checked outside reset.
`define GBEM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every edge, reset included.
`define GBEM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/gbem_pkg.sv]
// ----------------------------------------------------------------------------
// gbem_pkg
// Types and constants for the grain boundary energy/mobility pipeline.
// ----------------------------------------------------------------------------
package gbem_pkg;

  localparam int ANGLE_W  = 16;             // Q8.8 angle
  localparam int ENERGY_W = 26;             // Q2.24 energy
  localparam int MOB_W    = 32;             // mobility, units of 1e-12
  localparam int X_W      = ANGLE_W + 1;    // x in Q1.16, up to 1.0
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int DIV_STAGES = X_W;          // one quotient bit per stage

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HIGH_ANGLE_LIMIT    = 3'd0,
    REG_HIGH_ANGLE_ENERGY   = 3'd1,
    REG_HIGH_ANGLE_MOBILITY = 3'd2,
    REG_TENSILE_TWIN_ENERGY = 3'd3,
    REG_COMPRESS_TWIN_ENERGY = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    TWIN_OTHER    = 2'd0,
    TWIN_TENSILE  = 2'd1,
    TWIN_COMPRESS = 2'd2
  } twin_kind_t;

  localparam logic [ANGLE_W-1:0]  RST_LIMIT    = 16'd3840;
  localparam logic [ENERGY_W-1:0] RST_E_HIGH   = 26'd15099494;
  localparam logic [MOB_W-1:0]    RST_M_HIGH   = 32'd2500000;
  localparam logic [ENERGY_W-1:0] RST_E_TT1    = 26'd42;
  localparam logic [ENERGY_W-1:0] RST_E_CT1    = 26'd42;

  localparam logic [31:0] LN2_Q32   = 32'hB17217F8;
  localparam logic [15:0] RECIP6    = 16'd43691;  // ceil(2^18/6)
  localparam int          RECIP6_SH = 18;
  localparam logic [11:0] RECIP24   = 12'd2731;   // ceil(2^16/24)
  localparam int          RECIP24_SH = 16;

  // Per-item sideband carried down the whole pipe.
  typedef struct packed {
    logic       low;   // angle at or below the high-angle limit
    logic       twin;
    logic [1:0] kind;
  } side_t;

endpackage

[rtl/gbem_div.sv]
// ----------------------------------------------------------------------------
// gbem_div
// Pipelined restoring divider: quo = (angle << 16) / lim, for angle <= lim.
// ----------------------------------------------------------------------------
module gbem_div import gbem_pkg::*; (
  input  logic                  clk,
  input  logic [DIV_STAGES-1:0] en,
  input  logic [ANGLE_W-1:0]    angle,
  input  logic [ANGLE_W-1:0]    lim,
  output logic [X_W-1:0]        quo
);

  logic [ANGLE_W-1:0] rem [0:DIV_STAGES-1];
  logic [ANGLE_W-1:0] dl  [0:DIV_STAGES-1];
  logic [X_W-1:0]     qr  [0:DIV_STAGES-1];

  // Integer bit: with angle <= lim it is set only when they are equal.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      dl[0]  <= lim;
      qr[0]  <= {{(X_W-1){1'b0}}, angle == lim};
      rem[0] <= (angle == lim) ? '0 : angle;
    end
  end

  for (genvar i = 1; i < DIV_STAGES; i++) begin : g_step
    logic [ANGLE_W:0] rem2;
    logic [ANGLE_W:0] diff;
    logic             ge;
    assign rem2 = {rem[i-1], 1'b0};
    assign diff = rem2 - {1'b0, dl[i-1]};
    assign ge   = rem2 >= {1'b0, dl[i-1]};
    always_ff @(posedge clk) begin
      if (en[i]) begin
        dl[i]  <= dl[i-1];
        rem[i] <= ge ? diff[ANGLE_W-1:0] : rem2[ANGLE_W-1:0];
        qr[i]  <= {qr[i-1][X_W-2:0], ge};
      end
    end
  end

  assign quo = qr[DIV_STAGES-1];

endmodule

[rtl/grain_boundary_energy_mobility.sv]
// ----------------------------------------------------------------------------
// grain_boundary_energy_mobility
// Read-Shockley boundary energy and exponential mobility law, fully pipelined.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata                  | tuser
//  s_axis   | in        | [15:0] angle Q8.8      | [0] twin_flag, [2:1] twin_kind
//  m_axis   | out       | [25:0] energy [57:26] mob | -
//  cfg      | in        | cfg_wr_en / cfg_index / cfg_data, write only
//
//  One transfer per cycle in and out unless m_axis stalls. The depth is set by
//  the 17-step divider, the 16 log2 squarings and the output multiplies.
//  Reset (rst, synchronous) empties the pipe and loads register defaults.
//  Each stage holds only when full and the stage after it holds, so bubbles
//  fill in and input flows while a result waits at m_axis until the pipe fills.
// ----------------------------------------------------------------------------
module grain_boundary_energy_mobility import gbem_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [15:0]           s_axis_tdata,   // [15:0] misorientation_angle
  input  logic [2:0]            s_axis_tuser,   // [0] twin_flag, [2:1] twin_kind
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [63:0]           m_axis_tdata,   // [25:0] boundary_energy,
                                                // [57:26] boundary_mobility
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Stage map
  localparam int ST_X    = DIV_STAGES;   // 17: select x
  localparam int ST_PM   = ST_X + 1;     // 18: msb, normalize, x^2
  localparam int ST_LOG0 = ST_PM + 1;    // 19..34: log2 fraction bits
  localparam int ST_LOGL = ST_PM + 16;
  localparam int ST_X4   = ST_PM + 1;    // 19: x^4, t
  localparam int ST_S2   = ST_X4 + 1;
  localparam int ST_S3   = ST_S2 + 1;
  localparam int ST_S4   = ST_S3 + 1;    // also s3/6
  localparam int ST_Q24  = ST_S4 + 1;
  localparam int ST_E    = ST_Q24 + 1;   // series sum
  localparam int ST_SQ0  = ST_E + 1;     // 25..32: eight squarings
  localparam int ST_SQL  = ST_E + 8;
  localparam int ST_G    = ST_SQL + 1;   // 33
  localparam int ST_MOB  = ST_G + 1;     // 34
  localparam int ST_LN   = ST_LOGL + 1;  // 35
  localparam int ST_F    = ST_LN + 1;    // 36
  localparam int ST_OUT  = ST_F + 1;     // 37
  localparam int N_STG   = ST_OUT + 1;

  // ---------------- configuration registers ----------------
  logic [ANGLE_W-1:0]  high_angle_limit;
  logic [ENERGY_W-1:0] high_angle_energy;
  logic [MOB_W-1:0]    high_angle_mobility;
  logic [ENERGY_W-1:0] tensile_twin_energy;
  logic [ENERGY_W-1:0] compression_twin_energy;

  always_ff @(posedge clk) begin
    if (rst) begin
      high_angle_limit        <= RST_LIMIT;
      high_angle_energy       <= RST_E_HIGH;
      high_angle_mobility     <= RST_M_HIGH;
      tensile_twin_energy     <= RST_E_TT1;
      compression_twin_energy <= RST_E_CT1;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_HIGH_ANGLE_LIMIT:     high_angle_limit        <= cfg_data[ANGLE_W-1:0];
        REG_HIGH_ANGLE_ENERGY:    high_angle_energy       <= cfg_data[ENERGY_W-1:0];
        REG_HIGH_ANGLE_MOBILITY:  high_angle_mobility     <= cfg_data[MOB_W-1:0];
        REG_TENSILE_TWIN_ENERGY:  tensile_twin_energy     <= cfg_data[ENERGY_W-1:0];
        REG_COMPRESS_TWIN_ENERGY: compression_twin_energy <= cfg_data[ENERGY_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- flow control ----------------
  logic [N_STG-1:0] vld;
  logic [N_STG:0]   en;

  assign en[N_STG] = m_axis_tready;
  for (genvar k = 0; k < N_STG; k++) begin : g_en
    assign en[k] = !vld[k] || en[k+1];
  end
  assign s_axis_tready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= s_axis_tvalid;
      for (int k = 1; k < N_STG; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // ---------------- input, sideband ----------------
  logic [ANGLE_W-1:0] lim_eff;
  logic [ANGLE_W-1:0] in_angle;
  side_t              in_side;
  side_t              side [0:N_STG-1];

  assign in_angle     = s_axis_tdata[ANGLE_W-1:0];
  assign lim_eff      = (high_angle_limit == '0) ? {{(ANGLE_W-1){1'b0}}, 1'b1}
                                                 : high_angle_limit;
  assign in_side.low  = in_angle <= lim_eff;
  assign in_side.twin = s_axis_tuser[0];
  assign in_side.kind = s_axis_tuser[2:1];

  always_ff @(posedge clk) begin
    if (en[0]) side[0] <= in_side;
    for (int k = 1; k < N_STG; k++) begin
      if (en[k]) side[k] <= side[k-1];
    end
  end

  // ---------------- x = angle / limit ----------------
  logic [X_W-1:0] quo;

  gbem_div u_div (
    .clk   (clk),
    .en    (en[DIV_STAGES-1:0]),
    .angle (in_angle),
    .lim   (lim_eff),
    .quo   (quo)
  );

  logic [X_W-1:0] x16 [ST_X:ST_F];

  always_ff @(posedge clk) begin
    if (en[ST_X]) x16[ST_X] <= side[ST_X-1].low ? quo : {1'b1, {(X_W-1){1'b0}}};
    for (int k = ST_X + 1; k <= ST_F; k++) begin
      if (en[k]) x16[k] <= x16[k-1];
    end
  end

  // ---------------- -ln x: normalize and log2 by squaring ----------------
  logic [4:0]  msb_c;
  logic [46:0] norm_c;
  logic [33:0] x2_prod;

  always_comb begin
    msb_c = '0;
    for (int i = 0; i < X_W; i++) begin
      if (x16[ST_X][i]) msb_c = 5'(i);
    end
  end
  assign norm_c  = {30'd0, x16[ST_X]} << (5'd30 - msb_c);
  assign x2_prod = x16[ST_X] * x16[ST_X];

  logic [4:0]  msb_r [ST_PM:ST_LN-1];
  logic [30:0] lm    [ST_PM:ST_LOGL];
  logic [15:0] lf    [ST_PM:ST_LOGL];
  logic [16:0] x2_r;

  always_ff @(posedge clk) begin
    if (en[ST_PM]) begin
      msb_r[ST_PM] <= msb_c;
      lm[ST_PM]    <= norm_c[30:0];
      lf[ST_PM]    <= '0;
      x2_r         <= x2_prod[32:16];
    end
    for (int k = ST_PM + 1; k < ST_LN; k++) begin
      if (en[k]) msb_r[k] <= msb_r[k-1];
    end
  end

  for (genvar k = ST_LOG0; k <= ST_LOGL; k++) begin : g_log
    logic [61:0] sq;
    logic [31:0] sh;
    assign sq = lm[k-1] * lm[k-1];
    assign sh = sq[61:30] ;
    always_ff @(posedge clk) begin
      if (en[k]) begin
        lm[k] <= sh[31] ? sh[31:1] : sh[30:0];
        lf[k] <= {lf[k-1][14:0], sh[31]};
      end
    end
  end

  // L = (16 - msb) * 2^16 - frac, scaled by ln 2
  logic [20:0] nl2;
  logic [52:0] ln_prod;
  logic [20:0] ln_r;

  assign nl2     = {(5'd16 - msb_r[ST_LOGL]), 16'd0} - {5'd0, lf[ST_LOGL]};
  assign ln_prod = nl2 * LN2_Q32;

  always_ff @(posedge clk) begin
    if (en[ST_LN]) ln_r <= ln_prod[52:32];
  end

  // f = min(1.0, x * (1 - ln x))
  logic [21:0] one_ln;
  logic [38:0] f_prod;
  logic [16:0] f_r;

  assign one_ln = {1'b0, ln_r} + 22'd65536;
  assign f_prod = x16[ST_F-1] * one_ln;

  always_ff @(posedge clk) begin
    if (en[ST_F]) f_r <= (f_prod[38:16] > 23'd65536) ? 17'd65536 : f_prod[32:16];
  end

  // ---------------- mobility: 1 - exp(-5 x^4) ----------------
  logic [33:0] x4_prod;
  logic [16:0] x4_c;
  logic [18:0] t_c;

  assign x4_prod = x2_r * x2_r;
  assign x4_c    = x4_prod[32:16];
  assign t_c     = ({2'd0, x4_c} << 2) + {2'd0, x4_c};   // 5 * x^4

  logic [26:0] s_r  [ST_X4:ST_S4-1];
  logic [21:0] s2_r [ST_S2:ST_E-1];
  logic [16:0] s3_r;
  logic [11:0] s4_r;
  logic [14:0] q6_r [ST_S4:ST_E-1];
  logic [7:0]  q24_r;
  logic        tz   [ST_X4:ST_G-1];
  logic [31:0] ee   [ST_E:ST_SQL];

  logic [53:0] s2_prod;
  logic [48:0] s3_prod;
  logic [43:0] s4_prod;
  logic [32:0] q6_prod;
  logic [23:0] q24_prod;

  assign s2_prod  = s_r[ST_S2-1] * s_r[ST_S2-1];
  assign s3_prod  = s2_r[ST_S3-1] * s_r[ST_S3-1];
  assign s4_prod  = s3_r * s_r[ST_S4-1];
  assign q6_prod  = s3_r * RECIP6;
  assign q24_prod = s4_r * RECIP24;

  logic [26:0] s_keep;
  assign s_keep = s_r[ST_S4-1];

  // s is carried into the series sum through its own registers, s_e and s_e2
  logic [26:0] s_e;
  logic [26:0] s_e2;
  logic [33:0] e_c;
  assign e_c = 34'h1_0000_0000 - {7'd0, s_e2} + {13'd0, s2_r[ST_E-1][21:1]}
             + {26'd0, q24_r} - {19'd0, q6_r[ST_E-1]};

  always_ff @(posedge clk) begin
    if (en[ST_X4]) begin
      s_r[ST_X4] <= {t_c, 8'd0};
      tz[ST_X4]  <= (x4_c == '0);
    end
    for (int k = ST_X4 + 1; k < ST_G; k++) begin
      if (en[k]) tz[k] <= tz[k-1];
    end
    for (int k = ST_X4 + 1; k < ST_S4; k++) begin
      if (en[k]) s_r[k] <= s_r[k-1];
    end
    if (en[ST_S2]) s2_r[ST_S2] <= s2_prod[53:32];
    for (int k = ST_S2 + 1; k < ST_E; k++) begin
      if (en[k]) s2_r[k] <= s2_r[k-1];
    end
    if (en[ST_S3]) s3_r <= s3_prod[48:32];
    if (en[ST_S4]) begin
      s4_r        <= s4_prod[43:32];
      q6_r[ST_S4] <= q6_prod[32:RECIP6_SH];
      s_e         <= s_keep;
    end
    if (en[ST_Q24]) begin
      q24_r        <= q24_prod[23:RECIP24_SH];
      q6_r[ST_Q24] <= q6_r[ST_S4];
    end
    if (en[ST_E]) ee[ST_E] <= e_c[31:0];
  end

  // s_e must follow the item one more stage, to the series sum
  always_ff @(posedge clk) begin
    if (en[ST_Q24]) s_e2 <= s_e;
  end

  for (genvar k = ST_SQ0; k <= ST_SQL; k++) begin : g_sq
    logic [63:0] sq;
    assign sq = ee[k-1] * ee[k-1];
    always_ff @(posedge clk) begin
      if (en[k]) ee[k] <= sq[63:32];
    end
  end

  logic [31:0] g_r;
  logic [63:0] mob_prod;
  logic [31:0] mob_r [ST_MOB:ST_OUT-1];

  assign mob_prod = high_angle_mobility * g_r;

  always_ff @(posedge clk) begin
    if (en[ST_G]) begin
      if (tz[ST_G-1])              g_r <= '0;
      else if (ee[ST_SQL] == '0)   g_r <= '1;
      else                         g_r <= 32'd0 - ee[ST_SQL];
    end
    if (en[ST_MOB]) mob_r[ST_MOB] <= mob_prod[63:32];
    for (int k = ST_MOB + 1; k < ST_OUT; k++) begin
      if (en[k]) mob_r[k] <= mob_r[k-1];
    end
  end

  // ---------------- output stage ----------------
  logic [42:0]         e_prod;
  logic [ENERGY_W-1:0] energy_c;
  logic [MOB_W-1:0]    mob_c;
  side_t               sd;
  logic [ENERGY_W-1:0] energy_r;
  logic [MOB_W-1:0]    mobility_r;

  assign sd     = side[ST_F];
  assign e_prod = high_angle_energy * f_r;

  always_comb begin
    if (sd.low && !sd.twin) begin
      energy_c = (x16[ST_F] == '0) ? '0 : e_prod[41:16];
    end else if (sd.twin && sd.kind == TWIN_TENSILE) begin
      energy_c = tensile_twin_energy;
    end else if (sd.twin && sd.kind == TWIN_COMPRESS) begin
      energy_c = compression_twin_energy;
    end else begin
      energy_c = high_angle_energy;
    end
    mob_c = sd.low ? mob_r[ST_OUT-1] : high_angle_mobility;
  end

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      energy_r   <= energy_c;
      mobility_r <= mob_c;
    end
  end

  assign m_axis_tvalid = vld[ST_OUT];
  assign m_axis_tdata  = {6'd0, mobility_r, energy_r};

endmodule

[rtl/gbem_chk.sv]
// ----------------------------------------------------------------------------
// gbem_chk
// Port-level checks for the grain boundary energy/mobility pipeline.
// ----------------------------------------------------------------------------
`include "grain_boundary_energy_mobility_macros.svh"

module gbem_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);

  // A stalled result keeps its transfer payload.
  `GBEM_ASSERT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "output changed while stalled")

  // Reset empties the pipe.
  `GBEM_ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !m_axis_tvalid, "result valid after reset")

  // A draining output never back-pressures the input.
  `GBEM_ASSERT(a_ready_flow, clk, rst, m_axis_tready |-> s_axis_tready, "input stalled while output drains")

  // An empty output slot means the pipe can shift.
  `GBEM_ASSERT(a_ready_empty, clk, rst, !m_axis_tvalid |-> s_axis_tready, "input stalled with empty output")

endmodule

bind grain_boundary_energy_mobility gbem_chk u_gbem_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
